// File: rtl/sbt_pkg.sv
// shared widths, register indexes, config struct and helper functions
package sbt_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int MAX_BOX    = 256;

    localparam int POS_W      = 14;
    localparam int STEP_W     = 10;
    localparam int CNT_W      = 25;
    localparam int BOX_W      = 9;
    localparam int DIM_W      = 13;
    localparam int SIDE_W     = 13;
    localparam int OFF_W      = DIM_W - 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE    = 2'd3;

    localparam logic [BOX_W-1:0]  BOX_SIZE_RST     = 9'd16;
    localparam logic [DIM_W-1:0]  IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]  IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [SIDE_W-1:0] GRID_SIDE_RST    = 13'd41;

    // values derived at write time so the step path stays short
    typedef struct packed {
        logic [BOX_W-1:0] box_size;
        logic [OFF_W-1:0] x_off;
        logic [OFF_W-1:0] y_off;
        logic [CNT_W-1:0] last_cnt;
    } t_cfg;

    // index of the final tile: side squared, clamped to the counter range, minus one
    function automatic logic [CNT_W-1:0] last_count(input logic [SIDE_W-1:0] side);
        logic [SIDE_W-1:0]   s;
        logic [2*SIDE_W-1:0] total;
        s     = (side == '0) ? SIDE_W'(1) : side;
        total = s * s;
        if (total > ((2*SIDE_W)'(1) << CNT_W)) begin
            total = (2*SIDE_W)'(1) << CNT_W;
        end
        return CNT_W'(total - (2*SIDE_W)'(1));
    endfunction

    // center offset (d-1)/2, zero for an empty axis
    function automatic logic [OFF_W-1:0] center_off(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] dm;
        dm = d - DIM_W'(1);
        return (d == '0) ? '0 : dm[DIM_W-1:1];
    endfunction

endpackage

// File: rtl/sbt_in_if.sv
// input channel: one tick item carrying the restart flag
interface sbt_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source(output valid, output restart, input ready);
    modport sink(input valid, input restart, output ready);
endinterface

// File: rtl/sbt_out_if.sv
// output channel: one tile corner item
interface sbt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sbt_pkg::POS_W-1:0]   tile_x;
    logic signed [sbt_pkg::POS_W-1:0]   tile_y;
    logic                               is_last;

    modport source(output valid, output tile_x, output tile_y, output is_last, input ready);
    modport sink(input valid, input tile_x, input tile_y, input is_last, output ready);
endinterface

// File: rtl/sbt_cfg.sv
// configuration registers with precomputed offsets and final tile index
module sbt_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [sbt_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [sbt_pkg::CFG_DATA_W-1:0]   i_data,
    output sbt_pkg::t_cfg                    o_cfg
);

    sbt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_size <= sbt_pkg::BOX_SIZE_RST;
            r_cfg.x_off    <= sbt_pkg::center_off(sbt_pkg::IMAGE_WIDTH_RST);
            r_cfg.y_off    <= sbt_pkg::center_off(sbt_pkg::IMAGE_HEIGHT_RST);
            r_cfg.last_cnt <= sbt_pkg::last_count(sbt_pkg::GRID_SIDE_RST);
        end else if (i_we) begin
            unique case (i_idx)
                sbt_pkg::REG_BOX_SIZE: begin
                    r_cfg.box_size <= i_data[sbt_pkg::BOX_W-1:0];
                end
                sbt_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg.x_off <= sbt_pkg::center_off(i_data[sbt_pkg::DIM_W-1:0]);
                end
                sbt_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg.y_off <= sbt_pkg::center_off(i_data[sbt_pkg::DIM_W-1:0]);
                end
                sbt_pkg::REG_GRID_SIDE: begin
                    r_cfg.last_cnt <= sbt_pkg::last_count(i_data[sbt_pkg::SIDE_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/sbt_core.sv
// spiral position state and one-step walk logic
module sbt_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sbt_pkg::t_cfg                    i_cfg,
    input  logic                             i_step,
    input  logic                             i_restart,
    output logic signed [sbt_pkg::POS_W-1:0] o_tile_x,
    output logic signed [sbt_pkg::POS_W-1:0] o_tile_y,
    output logic                             o_is_last
);

    localparam int P = sbt_pkg::POS_W;
    localparam int S = sbt_pkg::STEP_W;
    localparam int C = sbt_pkg::CNT_W;
    localparam int B = sbt_pkg::BOX_W;

    logic signed [P-1:0] r_x, r_y;
    logic        [S-1:0] r_sx, r_sy;
    logic        [C-1:0] r_cnt;

    logic signed [P-1:0] n_x, n_y;
    logic        [S-1:0] n_sx, n_sy;
    logic        [C-1:0] n_cnt;

    logic signed [P-1:0] cur_x, cur_y;
    logic        [S-1:0] cur_sx, cur_sy, home_sy, nsx, nsy;
    logic        [C-1:0] cur_cnt;
    logic signed [P:0]   neg_y;
    logic signed [P+1:0] box_minus_y;
    logic                turn, last;

    assign home_sy = -S'(i_cfg.box_size);

    always_comb begin
        // restart puts the walk back at the center before this tile
        cur_x   = i_restart ? '0 : r_x;
        cur_y   = i_restart ? '0 : r_y;
        cur_sx  = i_restart ? '0 : r_sx;
        cur_sy  = i_restart ? home_sy : r_sy;
        cur_cnt = i_restart ? '0 : r_cnt;

        last     = (cur_cnt == i_cfg.last_cnt);
        o_tile_x = cur_x + $signed(P'(i_cfg.x_off));
        o_tile_y = cur_y + $signed(P'(i_cfg.y_off));
        o_is_last = last;

        // corner tests of the square spiral
        neg_y       = -$signed({cur_y[P-1], cur_y});
        box_minus_y = $signed({{(P+2-B){1'b0}}, i_cfg.box_size})
                    - $signed({{2{cur_y[P-1]}}, cur_y});
        turn = (cur_x == cur_y)
            || (cur_x[P-1] && ($signed({cur_x[P-1], cur_x}) == neg_y))
            || (!cur_x[P-1] && (cur_x != '0)
                && ($signed({{2{cur_x[P-1]}}, cur_x}) == box_minus_y));

        nsx = turn ? -cur_sy : cur_sx;
        nsy = turn ? cur_sx : cur_sy;

        if (last) begin
            n_x   = '0;
            n_y   = '0;
            n_sx  = '0;
            n_sy  = home_sy;
            n_cnt = '0;
        end else begin
            n_x   = cur_x + $signed({{(P-S){nsx[S-1]}}, nsx});
            n_y   = cur_y + $signed({{(P-S){nsy[S-1]}}, nsy});
            n_sx  = nsx;
            n_sy  = nsy;
            n_cnt = cur_cnt + C'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x   <= '0;
            r_y   <= '0;
            r_sx  <= '0;
            r_sy  <= -S'(sbt_pkg::BOX_SIZE_RST);
            r_cnt <= '0;
        end else if (i_step) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_cnt <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    // the walk moves along one axis at a time
    a_one_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sx == '0) || (r_sy == '0))
        else $error("spiral step moves on both axes");

    // an ordinary step advances the tile count by one
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_restart && !last |=> r_cnt == $past(r_cnt) + C'(1))
        else $error("tile count did not advance");
`endif

endmodule

// File: rtl/spiral_box_tile_order_generator.sv
// top level of the square-spiral tile order generator
// usage:
//   i_in carries one tick item per tile wanted; its restart bit sends the
//   walk back to the image center before that tile is produced
//   o_out returns one item per tick: the tile corner (tile_x, tile_y) and
//   is_last on the final tile of the spiral, after which the walk restarts
//   configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no item is in flight: box_size, image_width, image_height, grid_side
// latency: the result is registered, so it is valid the cycle after the
//   tick is accepted
// throughput: one item per cycle while o_out is not held; the step is a
//   compare, swap and add in the walk logic, and the output register lets
//   the next tick enter in the same cycle that the previous corner is taken
// stall: while o_out is held (valid, not ready) i_in.ready drops and the
//   walk state does not move
// reset: synchronous active low; registers return to 16/640/480/41, the
//   walk sits at the center heading up and the output is empty
module spiral_box_tile_order_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sbt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sbt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    sbt_in_if.sink                          i_in,
    sbt_out_if.source                       o_out
);

    sbt_pkg::t_cfg cfg;

    logic                              accept;
    logic signed [sbt_pkg::POS_W-1:0]  tile_x, tile_y;
    logic                              is_last;

    // output register
    logic                              r_valid;
    logic signed [sbt_pkg::POS_W-1:0]  r_tile_x, r_tile_y;
    logic                              r_is_last;

    sbt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // a tick enters when the output slot is empty or being drained
    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    sbt_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_step    (accept),
        .i_restart (i_in.restart),
        .o_tile_x  (tile_x),
        .o_tile_y  (tile_y),
        .o_is_last (is_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tile_x  <= tile_x;
            r_tile_y  <= tile_y;
            r_is_last <= is_last;
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.tile_x  = r_tile_x;
    assign o_out.tile_y  = r_tile_y;
    assign o_out.is_last = r_is_last;

`ifndef NO_ASSERTIONS
    // every accepted tick shows up as a result in the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted tick produced no result");

    // output slot is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif

endmodule
